/* design/ddi_pkg.sv */
`timescale 1ns / 1ps

package ddi_pkg;

    // operand width of the shared multiplier and its product
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // item kinds carried in s_tuser
    typedef enum logic [1:0] {
        KIND_INTEGRATE = 2'd0,
        KIND_SAVE      = 2'd1,
        KIND_REDO      = 2'd2,
        KIND_LOAD      = 2'd3
    } ddi_kind_t;

    // configuration register indexes
    localparam logic [1:0] REG_DECAY_COEF = 2'd0;
    localparam logic [1:0] REG_INPUT_GAIN = 2'd1;
    localparam logic [1:0] REG_HALF_STEP  = 2'd2;

    // multiplier operand selection
    typedef enum logic [1:0] {
        OP_DECAY,
        OP_GAIN,
        OP_HALF
    } ddi_mul_op_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECAY,
        ST_GAIN,
        ST_FIRST,
        ST_HALF,
        ST_SECOND,
        ST_LOAD
    } ddi_state_t;

    // controls from the sequencer to the datapath
    typedef struct packed {
        logic        mul_en;
        ddi_mul_op_t op;
        logic        t1_en;
        logic        nf_en;
        logic        step_done;
        logic        load_done;
    } ddi_ctrl_t;

endpackage

/* design/ddi_mul.sv */
`timescale 1ns / 1ps

module ddi_mul
    import ddi_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // registered signed product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

/* design/ddi_seq.sv */
`timescale 1ns / 1ps

module ddi_seq
    import ddi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      is_load,
    input  logic      out_free,
    output logic      idle,
    output ddi_ctrl_t ctrl
);

    ddi_state_t state_reg;
    ddi_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and controls
    always_comb
    begin
        state_next     = state_reg;
        ctrl           = '0;
        ctrl.op        = OP_DECAY;
        idle           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    state_next = is_load ? ST_LOAD : ST_DECAY;
                end
            end
            ST_DECAY:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.op     = OP_DECAY;
                state_next  = ST_GAIN;
            end
            ST_GAIN:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.op     = OP_GAIN;
                ctrl.t1_en  = 1'b1;
                state_next  = ST_FIRST;
            end
            ST_FIRST:
            begin
                ctrl.nf_en = 1'b1;
                state_next = ST_HALF;
            end
            ST_HALF:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.op     = OP_HALF;
                state_next  = ST_SECOND;
            end
            ST_SECOND:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    ctrl.step_done = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    ctrl.load_done = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/damped_double_integrator.sv */
`timescale 1ns / 1ps
// an integrate beat steps through DECAY, GAIN, FIRST, HALF, SECOND; a load beat through LOAD
// one beat at a time: SECOND and LOAD hold while the output register is full and not taken
// the single 33x33 multiplier is used three times per step, in DECAY, GAIN and HALF
// a result waiting in the output register does not block acceptance of the next beat
// reset: asynchronous active low; state and backups clear, coefficients take reset values

module damped_double_integrator
    import ddi_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // sample[31:0], load_first[63:32], load_second[95:64]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // first_integral[31:0], second_integral[63:32]
    output logic        m_tuser    // overflow[0]
);

    localparam int EFF_W = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam int SUM_W = 50;
    localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (EFF_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    // clamp to the value range, flag when clamped
    function automatic logic [32:0] saturate(input logic signed [SUM_W-1:0] x);
        logic [32:0] r;
        if (x > SAT_HI)
        begin
            r = {1'b1, SAT_HI[31:0]};
        end
        else if (x < SAT_LO)
        begin
            r = {1'b1, SAT_LO[31:0]};
        end
        else
        begin
            r = {1'b0, x[31:0]};
        end
        return r;
    endfunction

    // coefficients
    logic signed [31:0] decay_reg;
    logic signed [31:0] gain_reg;
    logic        [30:0] half_reg;

    // architectural state
    logic signed [31:0] first_reg;
    logic signed [31:0] second_reg;
    logic signed [31:0] prev_reg;
    logic signed [31:0] first_bk_reg;
    logic signed [31:0] second_bk_reg;
    logic signed [31:0] sample_bk_reg;

    // per-beat working registers
    logic               is_load_reg;
    logic signed [31:0] u_reg;
    logic signed [31:0] lf_reg;
    logic signed [31:0] ls_reg;
    logic signed [31:0] bf_reg;
    logic signed [31:0] bs_reg;
    logic signed [31:0] bp_reg;
    logic signed [33:0] t1_reg;
    logic signed [31:0] nf_reg;
    logic               ovf_reg;

    // output register
    logic               out_valid_reg;
    logic        [31:0] out_first_reg;
    logic        [31:0] out_second_reg;
    logic               out_ovf_reg;

    logic               idle;
    logic               in_beat;
    logic               out_free;
    ddi_ctrl_t          ctrl;
    ddi_kind_t          kind_in;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [MUL_W-1:0]  s_sum;
    logic signed [MUL_W-1:0]  f_sum;
    logic signed [SUM_W-1:0]  nf_raw;
    logic signed [SUM_W-1:0]  ns_raw;
    logic        [32:0]       nf_sat;
    logic        [32:0]       ns_sat;
    logic        [32:0]       lf_sat;
    logic        [32:0]       ls_sat;

    assign kind_in  = ddi_kind_t'(s_tuser);
    assign s_tready = idle;
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    ddi_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_beat),
        .is_load  (kind_in == KIND_LOAD),
        .out_free (out_free),
        .idle     (idle),
        .ctrl     (ctrl)
    );

    // multiplier operand selection
    assign s_sum = MUL_W'(u_reg) + MUL_W'(bp_reg);
    assign f_sum = MUL_W'(nf_reg) + MUL_W'(bf_reg);

    always_comb
    begin
        case (ctrl.op)
            OP_DECAY:
            begin
                mul_a = MUL_W'(decay_reg);
                mul_b = MUL_W'(bf_reg);
            end
            OP_GAIN:
            begin
                mul_a = MUL_W'(gain_reg);
                mul_b = s_sum;
            end
            OP_HALF:
            begin
                mul_a = {2'b00, half_reg};
                mul_b = f_sum;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ddi_mul u_mul (
        .clk  (clk),
        .en   (ctrl.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // sums with floor shifts of the product
    assign nf_raw = SUM_W'(t1_reg) + SUM_W'($signed(prod[64:16]));
    assign ns_raw = SUM_W'(bs_reg) + SUM_W'($signed(prod[64:16]));
    assign nf_sat = saturate(nf_raw);
    assign ns_sat = saturate(ns_raw);
    assign lf_sat = saturate(SUM_W'(lf_reg));
    assign ls_sat = saturate(SUM_W'(ls_reg));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= 32'sh4000_0000;
            gain_reg  <= '0;
            half_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DECAY_COEF: decay_reg <= cfg_data;
                REG_INPUT_GAIN: gain_reg  <= cfg_data;
                REG_HALF_STEP:  half_reg  <= cfg_data[30:0];
                default:        ;
            endcase
        end
    end

    // input capture, base selection and intermediate results
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            is_load_reg <= (kind_in == KIND_LOAD);
            u_reg       <= s_tdata[31:0];
            lf_reg      <= s_tdata[63:32];
            ls_reg      <= s_tdata[95:64];
            if (kind_in == KIND_REDO)
            begin
                bf_reg <= first_bk_reg;
                bs_reg <= second_bk_reg;
                bp_reg <= sample_bk_reg;
            end
            else
            begin
                bf_reg <= first_reg;
                bs_reg <= second_reg;
                bp_reg <= prev_reg;
            end
        end
        if (ctrl.t1_en)
        begin
            t1_reg <= prod[63:30];
        end
        if (ctrl.nf_en)
        begin
            nf_reg  <= nf_sat[31:0];
            ovf_reg <= nf_sat[32];
        end
    end

    // state and backups
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= '0;
            second_reg    <= '0;
            prev_reg      <= '0;
            first_bk_reg  <= '0;
            second_bk_reg <= '0;
            sample_bk_reg <= '0;
        end
        else
        begin
            if (in_beat && (kind_in == KIND_SAVE))
            begin
                first_bk_reg  <= first_reg;
                second_bk_reg <= second_reg;
                sample_bk_reg <= prev_reg;
            end
            if (ctrl.step_done)
            begin
                first_reg  <= nf_reg;
                second_reg <= ns_sat[31:0];
                prev_reg   <= u_reg;
            end
            else if (ctrl.load_done && is_load_reg)
            begin
                first_reg  <= lf_sat[31:0];
                second_reg <= ls_sat[31:0];
                prev_reg   <= u_reg;
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.step_done || ctrl.load_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (ctrl.step_done)
        begin
            out_first_reg  <= nf_reg;
            out_second_reg <= ns_sat[31:0];
            out_ovf_reg    <= ovf_reg || ns_sat[32];
        end
        else if (ctrl.load_done)
        begin
            out_first_reg  <= lf_sat[31:0];
            out_second_reg <= ls_sat[31:0];
            out_ovf_reg    <= lf_sat[32] || ls_sat[32];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_second_reg, out_first_reg};
    assign m_tuser  = out_ovf_reg;

endmodule
